FILE: design/brpr_pkg.sv
// Package for the bf16 rotary pair rotator: types, codes and helper functions.
// No dependencies; the top level, the stage files and the bench use it by scoped names.
`default_nettype none
package brpr_pkg;

    // Operand and product classes
    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_FIN  = 2'd1,
        CLS_INF  = 2'd2,
        CLS_NAN  = 2'd3
    } cls_t;

    localparam logic [15:0] BF16_QNAN = 16'h7FC0;
    localparam logic [14:0] BF16_INF  = 15'h7F80;
    localparam int unsigned SUM_W     = 61;     // aligned sum width
    localparam int unsigned MAX_ALIGN = 44;     // widest exact alignment
    localparam int unsigned STICKY_SH = 28;     // shift when the small term is sticky

    // Exact product: value = sig * 2^ex
    typedef struct packed {
        cls_t               cls;
        logic               sgn;
        logic [15:0]        sig;
        logic signed [9:0]  ex;
    } prod_t;

    // Decoded bf16 operand
    typedef struct packed {
        cls_t               cls;
        logic               sgn;
        logic [7:0]         sig;
        logic signed [8:0]  ex;
    } opnd_t;

    // Aligned sum, or a finished special result
    typedef struct packed {
        logic               spec;
        logic [15:0]        spec_bits;
        logic               sgn;
        logic [SUM_W-1:0]   m;
        logic signed [10:0] ex;
    } sum_t;

    // Normalized sum, leading one at the top bit
    typedef struct packed {
        logic               spec;
        logic [15:0]        spec_bits;
        logic               sgn;
        logic [SUM_W-1:0]   n;
        logic signed [11:0] biased;
    } norm_t;

    function automatic opnd_t bf16_decode(input logic [15:0] h);
        opnd_t o;
        o.sgn = h[15];
        o.sig = 8'd0;
        o.ex  = 9'sd0;
        if (h[14:7] == 8'hFF) begin
            o.cls = (h[6:0] != 7'd0) ? CLS_NAN : CLS_INF;
        end else if (h[14:7] == 8'h00) begin
            o.cls = (h[6:0] != 7'd0) ? CLS_FIN : CLS_ZERO;
            o.sig = {1'b0, h[6:0]};
            o.ex  = -9'sd133;
        end else begin
            o.cls = CLS_FIN;
            o.sig = {1'b1, h[6:0]};
            o.ex  = $signed({1'b0, h[14:7]}) - 9'sd134;
        end
        return o;
    endfunction

    // Index count from the top down to the leading one
    function automatic logic [5:0] lead_zeros(input logic [SUM_W-1:0] m);
        logic [5:0] cnt;
        logic       found;
        cnt   = 6'd0;
        found = 1'b0;
        for (int i = SUM_W - 1; i >= 0; i--) begin
            if (!found) begin
                if (m[i]) begin
                    found = 1'b1;
                end else begin
                    cnt = cnt + 6'd1;
                end
            end
        end
        return cnt;
    endfunction

endpackage
`default_nettype wire

FILE: design/brpr_if.sv
// Valid/ready channel interfaces for the rotator's input pair and result pair.
// No dependencies.
`default_nettype none
interface brpr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_half_bits;
    logic [15:0] second_half_bits;
    logic [15:0] cosine_bits;
    logic [15:0] sine_bits;

    modport source (output valid, first_half_bits, second_half_bits, cosine_bits,
                    sine_bits, input ready);
    modport sink   (input valid, first_half_bits, second_half_bits, cosine_bits,
                    sine_bits, output ready);
endinterface

interface brpr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rotated_first_bits;
    logic [15:0] rotated_second_bits;

    modport source (output valid, rotated_first_bits, rotated_second_bits, input ready);
    modport sink   (input valid, rotated_first_bits, rotated_second_bits, output ready);
endinterface
`default_nettype wire

FILE: design/bf16_rotary_pair_rotate.sv
// Top level of the bf16 rotary pair rotator: four-stage pipeline.
// Depends on brpr_pkg, brpr_if, brpr_mul, brpr_align, brpr_norm, brpr_round.
//
//  channel   dir  word
//  pair_in   in   first_half_bits, second_half_bits, cosine_bits, sine_bits
//  pair_out  out  rotated_first_bits, rotated_second_bits
//
// One word per cycle while pair_out is not stalled; pair_out.valid rises once the
// word has passed the product, sum, normalized and result registers.
// Stages: products, align and add, normalize, round.
// Reset clears the stage valid bits only.
// A stall on pair_out freezes every stage; pair_in.ready drops only then.
`default_nettype none
module bf16_rotary_pair_rotate (
    input  wire logic     clk,
    input  wire logic     rst_n,
    brpr_in_if.sink       pair_in,
    brpr_out_if.source    pair_out
);
    logic            adv;
    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    brpr_pkg::prod_t p_next [4];
    brpr_pkg::prod_t p_reg  [4];
    brpr_pkg::sum_t  s_next [2];
    brpr_pkg::sum_t  s_reg  [2];
    brpr_pkg::norm_t n_next [2];
    brpr_pkg::norm_t n_reg  [2];
    logic [15:0]     r_next [2];
    logic [15:0]     r_reg  [2];

    assign adv           = !v4_reg || pair_out.ready;
    assign pair_in.ready = adv;

    // products: x1*c, x2*s, x2*c, x1*s
    brpr_mul u_mul0 (.a_bits(pair_in.first_half_bits),  .b_bits(pair_in.cosine_bits),
                     .prod(p_next[0]));
    brpr_mul u_mul1 (.a_bits(pair_in.second_half_bits), .b_bits(pair_in.sine_bits),
                     .prod(p_next[1]));
    brpr_mul u_mul2 (.a_bits(pair_in.second_half_bits), .b_bits(pair_in.cosine_bits),
                     .prod(p_next[2]));
    brpr_mul u_mul3 (.a_bits(pair_in.first_half_bits),  .b_bits(pair_in.sine_bits),
                     .prod(p_next[3]));

    brpr_align u_aln0 (.p(p_reg[0]), .r_in(p_reg[1]), .neg(1'b1), .sum(s_next[0]));
    brpr_align u_aln1 (.p(p_reg[2]), .r_in(p_reg[3]), .neg(1'b0), .sum(s_next[1]));

    brpr_norm u_nrm0 (.sum(s_reg[0]), .nrm(n_next[0]));
    brpr_norm u_nrm1 (.sum(s_reg[1]), .nrm(n_next[1]));

    brpr_round u_rnd0 (.nrm(n_reg[0]), .res(r_next[0]));
    brpr_round u_rnd1 (.nrm(n_reg[1]), .res(r_next[1]));

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pair_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // advance payload, hold on stall
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg <= p_next;
            s_reg <= s_next;
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    assign pair_out.valid               = v4_reg;
    assign pair_out.rotated_first_bits  = r_reg[0];
    assign pair_out.rotated_second_bits = r_reg[1];
endmodule
`default_nettype wire

FILE: design/brpr_mul.sv
// Stage 1 logic: decode one bf16 pair of operands and form the exact product.
// Depends on brpr_pkg.
`default_nettype none
module brpr_mul (
    input  wire logic [15:0]    a_bits,
    input  wire logic [15:0]    b_bits,
    output brpr_pkg::prod_t     prod
);
    brpr_pkg::opnd_t a;
    brpr_pkg::opnd_t b;

    always_comb
    begin
        a = brpr_pkg::bf16_decode(a_bits);
        b = brpr_pkg::bf16_decode(b_bits);
        prod.sgn = a.sgn ^ b.sgn;
        prod.sig = 16'd0;
        prod.ex  = 10'sd0;
        // classify, then multiply finite operands
        if (a.cls == brpr_pkg::CLS_NAN || b.cls == brpr_pkg::CLS_NAN) begin
            prod.cls = brpr_pkg::CLS_NAN;
        end else if ((a.cls == brpr_pkg::CLS_INF && b.cls == brpr_pkg::CLS_ZERO) ||
                     (a.cls == brpr_pkg::CLS_ZERO && b.cls == brpr_pkg::CLS_INF)) begin
            prod.cls = brpr_pkg::CLS_NAN;
        end else if (a.cls == brpr_pkg::CLS_INF || b.cls == brpr_pkg::CLS_INF) begin
            prod.cls = brpr_pkg::CLS_INF;
        end else if (a.cls == brpr_pkg::CLS_ZERO || b.cls == brpr_pkg::CLS_ZERO) begin
            prod.cls = brpr_pkg::CLS_ZERO;
        end else begin
            prod.cls = brpr_pkg::CLS_FIN;
            prod.sig = {8'd0, a.sig} * {8'd0, b.sig};
            prod.ex  = 10'(a.ex) + 10'(b.ex);
        end
    end
endmodule
`default_nettype wire

FILE: design/brpr_align.sv
// Stage 2 logic: resolve special cases, align two products and add them.
// Depends on brpr_pkg.
`default_nettype none
module brpr_align (
    input  wire brpr_pkg::prod_t p,
    input  wire brpr_pkg::prod_t r_in,
    input  wire logic            neg,
    output brpr_pkg::sum_t       sum
);
    brpr_pkg::prod_t            r;
    brpr_pkg::prod_t            hi;
    brpr_pkg::prod_t            lo;
    logic signed [10:0]         diff;
    logic [brpr_pkg::SUM_W-1:0] a_val;
    logic [brpr_pkg::SUM_W-1:0] b_val;

    always_comb
    begin
        r      = r_in;
        r.sgn  = r_in.sgn ^ neg;
        hi     = p;
        lo     = r;
        diff   = 11'sd0;
        a_val  = '0;
        b_val  = '0;
        sum    = '0;

        if (p.cls == brpr_pkg::CLS_NAN || r.cls == brpr_pkg::CLS_NAN) begin
            sum.spec      = 1'b1;
            sum.spec_bits = brpr_pkg::BF16_QNAN;
        end else if (p.cls == brpr_pkg::CLS_INF && r.cls == brpr_pkg::CLS_INF) begin
            sum.spec      = 1'b1;
            sum.spec_bits = (p.sgn == r.sgn) ? {p.sgn, brpr_pkg::BF16_INF}
                                             : brpr_pkg::BF16_QNAN;
        end else if (p.cls == brpr_pkg::CLS_INF) begin
            sum.spec      = 1'b1;
            sum.spec_bits = {p.sgn, brpr_pkg::BF16_INF};
        end else if (r.cls == brpr_pkg::CLS_INF) begin
            sum.spec      = 1'b1;
            sum.spec_bits = {r.sgn, brpr_pkg::BF16_INF};
        end else if (p.cls == brpr_pkg::CLS_ZERO && r.cls == brpr_pkg::CLS_ZERO) begin
            sum.spec      = 1'b1;
            sum.spec_bits = {p.sgn & r.sgn, 15'd0};
        end else begin
            // pick the larger-exponent term; a zero term contributes nothing
            if (p.cls == brpr_pkg::CLS_ZERO) begin
                hi = r;
            end else if (r.cls == brpr_pkg::CLS_ZERO) begin
                hi = p;
            end else if (p.ex >= r.ex) begin
                hi = p;
                lo = r;
            end else begin
                hi = r;
                lo = p;
            end

            if (p.cls == brpr_pkg::CLS_ZERO || r.cls == brpr_pkg::CLS_ZERO) begin
                a_val  = brpr_pkg::SUM_W'(hi.sig);
                sum.ex = 11'(hi.ex);
                lo.sgn = hi.sgn;
            end else begin
                diff = 11'(hi.ex) - 11'(lo.ex);
                if (diff <= $signed(11'(brpr_pkg::MAX_ALIGN))) begin
                    a_val  = brpr_pkg::SUM_W'(hi.sig) << diff[5:0];
                    b_val  = brpr_pkg::SUM_W'(lo.sig);
                    sum.ex = 11'(lo.ex);
                end else begin
                    // small term only matters as a sticky bit
                    a_val  = brpr_pkg::SUM_W'(hi.sig) << brpr_pkg::STICKY_SH;
                    b_val  = brpr_pkg::SUM_W'(1);
                    sum.ex = 11'(hi.ex) - 11'(brpr_pkg::STICKY_SH);
                end
            end

            // signed magnitude add
            if (hi.sgn == lo.sgn) begin
                sum.m   = a_val + b_val;
                sum.sgn = hi.sgn;
            end else if (a_val >= b_val) begin
                sum.m   = a_val - b_val;
                sum.sgn = hi.sgn;
            end else begin
                sum.m   = b_val - a_val;
                sum.sgn = lo.sgn;
            end

            // exact cancellation gives +0
            if (sum.m == '0) begin
                sum.spec      = 1'b1;
                sum.spec_bits = 16'h0000;
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/brpr_norm.sv
// Stage 3 logic: find the leading one and left-justify the sum.
// Depends on brpr_pkg.
`default_nettype none
module brpr_norm (
    input  wire brpr_pkg::sum_t sum,
    output brpr_pkg::norm_t     nrm
);
    logic [5:0] lz;

    always_comb
    begin
        lz            = brpr_pkg::lead_zeros(sum.m);
        nrm.spec      = sum.spec;
        nrm.spec_bits = sum.spec_bits;
        nrm.sgn       = sum.sgn;
        nrm.n         = sum.m << lz;
        // biased = lead + ex + 127, lead = 60 - lz
        nrm.biased    = 12'(sum.ex) + 12'sd187 - $signed({6'd0, lz});
    end
endmodule
`default_nettype wire

FILE: design/brpr_round.sv
// Stage 4 logic: round to fp32 with flush of subnormals, then round to bf16.
// Depends on brpr_pkg.
`default_nettype none
module brpr_round (
    input  wire brpr_pkg::norm_t nrm,
    output logic [15:0]          res
);
    logic               rnd;
    logic [24:0]        q;
    logic signed [11:0] b2;
    logic [22:0]        mant;
    logic [30:0]        mag;
    logic [31:0]        t;

    always_comb
    begin
        // fp32 round to nearest even on the top 24 bits
        rnd  = nrm.n[36] && ((|nrm.n[35:0]) || nrm.n[37]);
        q    = {1'b0, nrm.n[60:37]} + {24'd0, rnd};
        b2   = nrm.biased + {11'd0, q[24]};
        mant = q[24] ? q[23:1] : q[22:0];
        if (nrm.biased >= 12'sd1) begin
            if (b2 >= 12'sd255) begin
                mag = 31'h7F800000;
            end else begin
                mag = {b2[7:0], mant};
            end
        end else if (nrm.biased == 12'sd0 && (&nrm.n[60:37])) begin
            // subnormal that rounds up to the smallest normal
            mag = 31'h00800000;
        end else begin
            mag = 31'd0;
        end
        // fp32 to bf16, nearest even
        t = {1'b0, mag} + 32'h7FFF + {31'd0, mag[16]};
        if (nrm.spec) begin
            res = nrm.spec_bits;
        end else begin
            res = {nrm.sgn, t[30:16]};
        end
    end
endmodule
`default_nettype wire

FILE: design/brpr_check.sv
// Port-level checker for the bf16 rotary pair rotator, bound to the top level.
// Depends on bf16_rotary_pair_rotate and its channel interfaces.
`default_nettype none
module brpr_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_first,
    input wire logic [15:0] out_second
);
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    // count words inside the pipeline
    always_comb
    begin
        inflight_next = inflight_reg + {2'd0, in_valid && in_ready}
                                     - {2'd0, out_valid && out_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_second))
        else $error("stalled result word changed");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result word without an accepted input");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more words in flight than pipeline stages");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with no result waiting");
endmodule

bind bf16_rotary_pair_rotate brpr_check u_brpr_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pair_in.valid),
    .in_ready   (pair_in.ready),
    .out_valid  (pair_out.valid),
    .out_ready  (pair_out.ready),
    .out_first  (pair_out.rotated_first_bits),
    .out_second (pair_out.rotated_second_bits)
);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking bench for the bf16 rotary pair rotator: random and corner-case pairs.
// Depends on brpr_pkg, brpr_if and the design top bf16_rotary_pair_rotate.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 830;
    localparam int DRAIN_TAIL = 16;

    // Exact value of a decoded term: sig * 2^ex
    typedef struct {
        brpr_pkg::cls_t  cls;
        bit              sgn;
        longint unsigned sig;
        int              ex;
    } term_t;

    typedef struct {
        logic [15:0] first_half;
        logic [15:0] second_half;
        logic [15:0] cosine;
        logic [15:0] sine;
        bit          wait_empty;
    } pair_word_t;

    typedef struct {
        logic [15:0] first_rot;
        logic [15:0] second_rot;
    } rot_word_t;

    logic clk;
    logic rst_n;

    brpr_in_if  pair_in ();
    brpr_out_if pair_out ();

    bf16_rotary_pair_rotate u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair_in  (pair_in),
        .pair_out (pair_out)
    );

    pair_word_t pending_pairs[$];
    rot_word_t  expected_rotations[$];
    int         words_queued;
    int         words_accepted;
    int         words_checked;
    int         special_results;
    int         error_count;
    int         cycle_count;
    bit         took_word;

    // Decode a bf16 pattern to its exact value
    function automatic term_t unpack_bf16(input logic [15:0] h);
        term_t t;
        t.sgn = h[15];
        t.sig = 64'd0;
        t.ex  = 0;
        if (h[14:7] == 8'hFF) begin
            t.cls = (h[6:0] != 7'd0) ? brpr_pkg::CLS_NAN : brpr_pkg::CLS_INF;
        end else if (h[14:7] == 8'h00) begin
            t.cls = (h[6:0] != 7'd0) ? brpr_pkg::CLS_FIN : brpr_pkg::CLS_ZERO;
            t.sig = 64'(h[6:0]);
            t.ex  = -133;
        end else begin
            t.cls = brpr_pkg::CLS_FIN;
            t.sig = 64'({1'b1, h[6:0]});
            t.ex  = int'(h[14:7]) - 134;
        end
        return t;
    endfunction

    function automatic term_t exact_product(input term_t a, input term_t b);
        term_t p;
        p.sgn = a.sgn ^ b.sgn;
        p.sig = 64'd0;
        p.ex  = 0;
        if (a.cls == brpr_pkg::CLS_NAN || b.cls == brpr_pkg::CLS_NAN) begin
            p.cls = brpr_pkg::CLS_NAN;
        end else if ((a.cls == brpr_pkg::CLS_INF && b.cls == brpr_pkg::CLS_ZERO) ||
                     (a.cls == brpr_pkg::CLS_ZERO && b.cls == brpr_pkg::CLS_INF)) begin
            p.cls = brpr_pkg::CLS_NAN;
        end else if (a.cls == brpr_pkg::CLS_INF || b.cls == brpr_pkg::CLS_INF) begin
            p.cls = brpr_pkg::CLS_INF;
        end else if (a.cls == brpr_pkg::CLS_ZERO || b.cls == brpr_pkg::CLS_ZERO) begin
            p.cls = brpr_pkg::CLS_ZERO;
        end else begin
            p.cls = brpr_pkg::CLS_FIN;
            p.sig = a.sig * b.sig;
            p.ex  = a.ex + b.ex;
        end
        return p;
    endfunction

    // Round sgn * m * 2^e to fp32 nearest-even, flushing subnormals, then to bf16
    function automatic logic [15:0] round_to_bf16(input bit sgn, input longint unsigned m,
                                                  input int e);
        int              lead;
        int              biased;
        int              sh;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned half;
        logic [31:0]     bits;
        logic [31:0]     rounded;
        lead = 63;
        while (m[lead] == 1'b0) lead--;
        biased = lead + e + 127;
        sh = (biased >= 1) ? lead - 23 : -149 - e;
        if (sh <= 0) begin
            q = m << (-sh);
        end else if (sh >= 65) begin
            q = 64'd0;
        end else begin
            half = 64'd1 << (sh - 1);
            if (sh == 64) begin
                q   = 64'd0;
                rem = m;
            end else begin
                q   = m >> sh;
                rem = m & ((64'd1 << sh) - 64'd1);
            end
            if (rem > half || (rem == half && q[0])) q++;
        end
        if (biased >= 1) begin
            if (q == (64'd1 << 24)) begin
                q = q >> 1;
                biased++;
            end
            if (biased >= 255) bits = 32'h7F80_0000;
            else bits = (32'(biased) << 23) | {9'd0, q[22:0]};
        end else begin
            bits = q[31:0];
        end
        if (bits[30:23] == 8'd0) bits = 32'd0;
        bits[31] = sgn;
        rounded = bits + 32'h7FFF + {31'd0, bits[16]};
        return rounded[31:16];
    endfunction

    // bf16 bits of a*b +/- c*d, products exact, one fp32 rounding
    function automatic logic [15:0] fused_pair(input term_t a, input term_t b,
                                               input term_t c, input term_t d,
                                               input bit subtract);
        term_t           p;
        term_t           r;
        term_t           hi;
        term_t           lo;
        longint unsigned big;
        longint unsigned tiny;
        longint unsigned m;
        bit              sgn;
        int              diff;
        int              ex;
        p = exact_product(a, b);
        r = exact_product(c, d);
        if (subtract) r.sgn = ~r.sgn;
        if (p.cls == brpr_pkg::CLS_NAN || r.cls == brpr_pkg::CLS_NAN)
            return brpr_pkg::BF16_QNAN;
        if (p.cls == brpr_pkg::CLS_INF && r.cls == brpr_pkg::CLS_INF)
            return (p.sgn == r.sgn) ? {p.sgn, brpr_pkg::BF16_INF} : brpr_pkg::BF16_QNAN;
        if (p.cls == brpr_pkg::CLS_INF) return {p.sgn, brpr_pkg::BF16_INF};
        if (r.cls == brpr_pkg::CLS_INF) return {r.sgn, brpr_pkg::BF16_INF};
        if (p.cls == brpr_pkg::CLS_ZERO && r.cls == brpr_pkg::CLS_ZERO)
            return {p.sgn & r.sgn, 15'd0};
        if (p.cls == brpr_pkg::CLS_ZERO) return round_to_bf16(r.sgn, r.sig, r.ex);
        if (r.cls == brpr_pkg::CLS_ZERO) return round_to_bf16(p.sgn, p.sig, p.ex);
        if (p.ex >= r.ex) begin
            hi = p;
            lo = r;
        end else begin
            hi = r;
            lo = p;
        end
        diff = hi.ex - lo.ex;
        if (diff <= 44) begin
            big  = hi.sig << diff;
            tiny = lo.sig;
            ex   = lo.ex;
        end else begin
            // small term only matters as a sticky bit
            big  = hi.sig << 28;
            tiny = 64'd1;
            ex   = hi.ex - 28;
        end
        if (hi.sgn == lo.sgn) begin
            m   = big + tiny;
            sgn = hi.sgn;
        end else if (big >= tiny) begin
            m   = big - tiny;
            sgn = hi.sgn;
        end else begin
            m   = tiny - big;
            sgn = lo.sgn;
        end
        if (m == 64'd0) return 16'h0000;
        return round_to_bf16(sgn, m, ex);
    endfunction

    function automatic rot_word_t rotate_pair(input pair_word_t w);
        rot_word_t res;
        term_t     x1;
        term_t     x2;
        term_t     c;
        term_t     s;
        x1 = unpack_bf16(w.first_half);
        x2 = unpack_bf16(w.second_half);
        c  = unpack_bf16(w.cosine);
        s  = unpack_bf16(w.sine);
        res.first_rot  = fused_pair(x1, c, x2, s, 1'b1);
        res.second_rot = fused_pair(x2, c, x1, s, 1'b0);
        return res;
    endfunction

    // Random bf16 with an exponent drawn from a band
    function automatic logic [15:0] rand_bf16(input int exp_lo, input int exp_hi);
        logic [15:0] h;
        h[15]   = 1'($urandom_range(0, 1));
        h[14:7] = 8'($urandom_range(exp_lo, exp_hi));
        h[6:0]  = 7'($urandom);
        return h;
    endfunction

    function automatic logic [15:0] pick_operand();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 15) return 16'($urandom);
        if (kind < 70) return rand_bf16(110, 140);
        if (kind < 78) return rand_bf16(0, 6);
        if (kind < 86) return rand_bf16(249, 254);
        if (kind < 90) return {1'($urandom), 15'd0};
        if (kind < 94) return {1'($urandom), 8'hFF, 7'd0};
        if (kind < 96) return {1'($urandom), 8'hFF, 7'($urandom_range(1, 127))};
        return {1'($urandom), 8'd0, 7'($urandom)};
    endfunction

    task automatic queue_pair(input logic [15:0] x1, input logic [15:0] x2,
                              input logic [15:0] c, input logic [15:0] s, input bit hold);
        pair_word_t w;
        w.first_half  = x1;
        w.second_half = x2;
        w.cosine      = c;
        w.sine        = s;
        w.wait_empty  = hold;
        pending_pairs.push_back(w);
        words_queued++;
    endtask

    // Clock and cycle limit
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_rotations.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Record accepted words and their predicted rotation
    always @(posedge clk)
    begin
        took_word <= rst_n && pair_in.valid && pair_in.ready;
        if (rst_n && pair_in.valid && pair_in.ready) begin
            pair_word_t w;
            w.first_half  = pair_in.first_half_bits;
            w.second_half = pair_in.second_half_bits;
            w.cosine      = pair_in.cosine_bits;
            w.sine        = pair_in.sine_bits;
            w.wait_empty  = 1'b0;
            expected_rotations.push_back(rotate_pair(w));
            words_accepted <= words_accepted + 1;
        end
    end

    // Sender: bursts and gaps, optional drain pause
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        bit         show;
        pair_word_t w;
        show = pair_in.valid && !took_word;
        if (rst_n && !show) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_pairs.size() > 0 &&
                         !(pending_pairs[0].wait_empty && expected_rotations.size() > 0)) begin
                w = pending_pairs.pop_front();
                pair_in.first_half_bits  <= w.first_half;
                pair_in.second_half_bits <= w.second_half;
                pair_in.cosine_bits      <= w.cosine;
                pair_in.sine_bits        <= w.sine;
                show = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        pair_in.valid <= show;
    end

    // Receiver: stall pattern plus one long hold once traffic is flowing
    int  hold_left;
    bit  long_hold_done;
    int  ready_mode;
    int  mode_left;
    always @(negedge clk)
    begin
        bit rdy;
        rdy = 1'b1;
        if (rst_n) begin
            if (!long_hold_done && words_accepted >= 300) begin
                long_hold_done = 1'b1;
                hold_left = 250;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 80);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (ready_mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 1) == 1);
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = (cycle_count % 5) < 3;
                endcase
            end
        end
        pair_out.ready <= rdy;
    end

    // Compare each delivered word against the oldest prediction
    always @(posedge clk)
    begin
        rot_word_t want;
        if (rst_n && pair_out.valid && pair_out.ready) begin
            if (expected_rotations.size() == 0) begin
                $error("result word with nothing expected: %h %h",
                       pair_out.rotated_first_bits, pair_out.rotated_second_bits);
                error_count++;
            end else begin
                want = expected_rotations.pop_front();
                if (pair_out.rotated_first_bits !== want.first_rot) begin
                    $error("rotated_first_bits expected %h got %h",
                           want.first_rot, pair_out.rotated_first_bits);
                    error_count++;
                end
                if (pair_out.rotated_second_bits !== want.second_rot) begin
                    $error("rotated_second_bits expected %h got %h",
                           want.second_rot, pair_out.rotated_second_bits);
                    error_count++;
                end
                if (want.first_rot[14:7] == 8'hFF || want.first_rot[14:0] == 15'd0)
                    special_results++;
                words_checked++;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        rst_n = 1'b0;
        pair_in.valid = 1'b0;
        pair_in.first_half_bits = 16'd0;
        pair_in.second_half_bits = 16'd0;
        pair_in.cosine_bits = 16'd0;
        pair_in.sine_bits = 16'd0;
        pair_out.ready = 1'b0;
        cycle_count = 0;
        words_queued = 0;
        words_accepted = 0;
        words_checked = 0;
        special_results = 0;
        error_count = 0;
        burst_left = 0;
        gap_left = 0;
        hold_left = 0;
        long_hold_done = 1'b0;
        mode_left = 0;
        ready_mode = 0;

        // Corner cases: zeros, signed zeros, cancellation, NaN, infinities, extremes
        queue_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_pair(16'h8000, 16'h0000, 16'h3F80, 16'h3F80, 1'b0);
        queue_pair(16'h8000, 16'h8000, 16'h3F80, 16'h8000, 1'b0);
        queue_pair(16'h3F80, 16'h3F80, 16'h3F80, 16'h3F80, 1'b0);
        queue_pair(16'h7FC0, 16'h3F80, 16'h3F80, 16'h3F80, 1'b0);
        queue_pair(16'h3F80, 16'hFFFF, 16'h3F80, 16'h0000, 1'b0);
        queue_pair(16'h7F80, 16'h3F80, 16'h0000, 16'h3F80, 1'b0);
        queue_pair(16'h7F80, 16'h7F80, 16'h3F80, 16'h3F80, 1'b0);
        queue_pair(16'h7F80, 16'hFF80, 16'h3F80, 16'h3F80, 1'b0);
        queue_pair(16'h3F80, 16'h7F80, 16'h3F80, 16'hBF80, 1'b0);
        queue_pair(16'h7F7F, 16'h7F7F, 16'h7F7F, 16'hFF7F, 1'b0);
        queue_pair(16'h7F7F, 16'h7F7F, 16'h3F80, 16'h3F80, 1'b0);
        queue_pair(16'h0080, 16'h0080, 16'h0080, 16'h0080, 1'b0);
        queue_pair(16'h0001, 16'h007F, 16'h3F80, 16'h3F80, 1'b0);
        queue_pair(16'h807F, 16'h0001, 16'h7F7F, 16'h7F00, 1'b0);
        queue_pair(16'h0100, 16'h0080, 16'h3F00, 16'h3E80, 1'b0);
        queue_pair(16'h3F81, 16'h3F80, 16'h3F7F, 16'h3F80, 1'b0);
        queue_pair(16'h4B80, 16'h3380, 16'h3F80, 16'h3F80, 1'b0);
        queue_pair(16'h3F80, 16'h0000, 16'h3F35, 16'h3F35, 1'b0);
        queue_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);

        // Random pairs; pause for a full drain once at the start and once midway
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if ($urandom_range(0, 4) == 0)
                queue_pair(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           i == 0 || i == 500);
            else
                queue_pair(pick_operand(), pick_operand(), rand_bf16(100, 127),
                           rand_bf16(100, 127), i == 0 || i == 500);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (words_accepted == words_queued);
        wait (expected_rotations.size() == 0);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("%0d pairs sent, %0d rotations checked, %0d zero or overflow results",
                 words_accepted, words_checked, special_results);
        if (error_count == 0 && expected_rotations.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

FILE: bf16_rotary_pair_rotate.f
design/brpr_pkg.sv
design/brpr_if.sv
design/brpr_mul.sv
design/brpr_align.sv
design/brpr_norm.sv
design/brpr_round.sv
design/bf16_rotary_pair_rotate.sv
design/brpr_check.sv
sim/testbench.sv
